[hw/rtl/sslfb_pkg.sv]
`default_nettype none
package sslfb_pkg;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REFRESH = 1'b1
  } cmd_t;

  localparam logic signed [15:0] VALUE_LIMIT = 16'sd1999;

  // Frame bit positions (bit 31 is the MSB)
  localparam int MINUS_BIT = 16;
  localparam int THOU_BIT  = 17;

  localparam logic [31:0] ONES_MASK = 32'h0000_00FE;
  localparam logic [31:0] TENS_MASK = 32'h0000_FE00;
  localparam logic [31:0] HUND_MASK = 32'h00FC_0100;

  // Annunciator frame bits by flag index: dot, K, J, E, T, N, S, B, W
  localparam logic [4:0] FLAG_BIT [9] = '{
    5'd0, 5'd31, 5'd30, 5'd29, 5'd28, 5'd26, 5'd27, 5'd24, 5'd25
  };

  // One queued beat between front and back
  typedef struct packed {
    logic        is_load;
    logic [31:0] steady;
    logic [31:0] blank;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_port_t;

  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // Segment s (a..g) of the ones digit lands on bit 7-s
  function automatic logic [31:0] place_ones(input logic [6:0] pat);
    logic [31:0] word;
    word = '0;
    for (int s = 0; s < 7; s++) begin
      word[7 - s] = pat[s];
    end
    return word;
  endfunction

  // Segment s of the tens digit lands on bit 15-s
  function automatic logic [31:0] place_tens(input logic [6:0] pat);
    logic [31:0] word;
    word = '0;
    for (int s = 0; s < 7; s++) begin
      word[15 - s] = pat[s];
    end
    return word;
  endfunction

  // Hundreds: a on bit 8, b..g on bits 23..18
  function automatic logic [31:0] place_hund(input logic [6:0] pat);
    logic [31:0] word;
    word = '0;
    word[8] = pat[0];
    for (int s = 1; s < 7; s++) begin
      word[24 - s] = pat[s];
    end
    return word;
  endfunction

  function automatic logic [31:0] flag_word(input logic [8:0] flags);
    logic [31:0] word;
    word = '0;
    for (int f = 0; f < 9; f++) begin
      word[FLAG_BIT[f]] = flags[f];
    end
    return word;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/seven_segment_lcd_frame_builder.sv]
`default_nettype none
// Channel   Handshake            Payload
// input     push / full          in_command, in_value, in_show_flags, in_blink_flags
// result    empty / pop          out_frame_word, out_blink_phase
//
// One beat is accepted every cycle while full is low; each beat is decoded in
// the cycle it arrives, and all but out-of-range loads are written into the
// QUEUE_DEPTH-entry queue. The back end retires one queued beat per cycle
// while the result is not stalled; each refresh result is held in a register.
// Synchronous active-low reset clears both frames, the phase, the queue and
// the result valid flag. A stalled result holds the back end only for a
// refresh beat at the queue head; a load there still drains, and full rises
// only when the queue is full.
module seven_segment_lcd_frame_builder import sslfb_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_command,
  input  wire logic signed [15:0] in_value,
  input  wire logic        [8:0]  in_show_flags,
  input  wire logic        [12:0] in_blink_flags,
  output logic                    empty,
  input  wire logic               pop,
  output logic             [31:0] out_frame_word,
  output logic                    out_blink_phase
);

  q_port_t q_wr;
  q_port_t q_rd;
  logic    q_full;
  logic    q_pop;

  // Front: classify the beat, decode loads into both frames
  sslfb_front u_front (
    .push           (push),
    .q_full         (q_full),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_show_flags  (in_show_flags),
    .in_blink_flags (in_blink_flags),
    .q_wr           (q_wr)
  );

  // Short queue decouples the decoder from the output stall
  sslfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_rd   (q_rd),
    .q_full (q_full)
  );

  // Back: hold the frames, toggle phase, drive the result register
  sslfb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_frame_word  (out_frame_word),
    .out_blink_phase (out_blink_phase)
  );

  assign full = q_full;

endmodule
`default_nettype wire

[hw/rtl/sslfb_front.sv]
`default_nettype none
module sslfb_front import sslfb_pkg::*; (
  input  wire logic               push,
  input  wire logic               q_full,
  input  wire logic               in_command,
  input  wire logic signed [15:0] in_value,
  input  wire logic        [8:0]  in_show_flags,
  input  wire logic        [12:0] in_blink_flags,
  output q_port_t                 q_wr
);

  logic        in_range;
  logic [15:0] abs16;
  logic [10:0] mag;
  logic        thou;
  logic [9:0]  mag_rem;
  logic [15:0] prod_h;
  logic [3:0]  hund;
  logic [6:0]  rem_h;
  logic [13:0] prod_t;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [31:0] frame;
  logic [31:0] blank;

  assign in_range = (in_value >= -VALUE_LIMIT) && (in_value <= VALUE_LIMIT);
  assign abs16    = in_value[15] ? 16'(-in_value) : in_value;
  assign mag      = abs16[10:0];
  assign thou     = (mag > 11'd999);
  assign mag_rem  = thou ? 10'(mag - 11'd1000) : mag[9:0];

  // Divide by 100 and by 10 with reciprocals, exact over these ranges
  assign prod_h = 16'(mag_rem) * 16'd41;
  assign hund   = prod_h[15:12];
  assign rem_h  = 7'(mag_rem - 10'(10'(hund) * 10'd100));
  assign prod_t = 14'(rem_h) * 14'd103;
  assign tens   = prod_t[13:10];
  assign ones   = 4'(rem_h - 7'(7'(tens) * 7'd10));

  always_comb begin
    frame = flag_word(in_show_flags) | place_ones(seg7(ones));
    frame[MINUS_BIT] = in_value[15];
    frame[THOU_BIT]  = thou;
    if (thou || (hund != 4'd0)) begin
      frame = frame | place_hund(seg7(hund));
    end
    if (thou || (hund != 4'd0) || (tens != 4'd0) || in_show_flags[0]) begin
      frame = frame | place_tens(seg7(tens));
    end

    blank = frame & ~flag_word(in_blink_flags[8:0]);
    if (in_blink_flags[9]) begin
      blank = blank & ~ONES_MASK;
    end
    if (in_blink_flags[10]) begin
      blank = blank & ~TENS_MASK;
    end
    if (in_blink_flags[11]) begin
      blank = blank & ~HUND_MASK;
    end
    if (in_blink_flags[12]) begin
      blank[THOU_BIT] = 1'b0;
    end
  end

  // Drop out-of-range loads; refresh ticks always go on
  always_comb begin
    q_wr.item.is_load = (in_command == CMD_LOAD);
    q_wr.item.steady  = frame;
    q_wr.item.blank   = blank;
    q_wr.valid        = push && !q_full &&
                        ((in_command == CMD_REFRESH) || in_range);
  end

endmodule
`default_nettype wire

[hw/rtl/sslfb_queue.sv]
`default_nettype none
module sslfb_queue import sslfb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_port_t q_wr,
  input  wire logic    q_pop,
  output q_port_t      q_rd,
  output logic         q_full
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_rd;

  assign q_full     = (count_r == CW'(DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.item  = mem_r[rd_ptr_r];
  assign do_rd      = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.valid) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : IW'(wr_ptr_r + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : IW'(rd_ptr_r + 1'b1);
    end
    if (q_wr.valid && !do_rd) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (!q_wr.valid && do_rd) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sslfb_back.sv]
`default_nettype none
module sslfb_back import sslfb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_port_t q_rd,
  output logic         q_pop,
  input  wire logic    pop,
  output logic         empty,
  output logic [31:0]  out_frame_word,
  output logic         out_blink_phase
);

  logic [31:0] steady_r, steady_nxt;
  logic [31:0] blank_r, blank_nxt;
  logic        phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_phase_r, out_phase_nxt;
  logic        out_free;
  logic        take_tick;

  assign out_free  = !out_valid_r || pop;
  assign q_pop     = q_rd.valid && (q_rd.item.is_load || out_free);
  assign take_tick = q_pop && !q_rd.item.is_load;

  always_comb begin
    steady_nxt    = steady_r;
    blank_nxt     = blank_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !pop;
    out_word_nxt  = out_word_r;
    out_phase_nxt = out_phase_r;
    if (q_pop && q_rd.item.is_load) begin
      steady_nxt = q_rd.item.steady;
      blank_nxt  = q_rd.item.blank;
    end
    if (take_tick) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = phase_r ? blank_r : steady_r;
      out_phase_nxt = phase_r;
      phase_nxt     = !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_r    <= '0;
      blank_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      steady_r    <= steady_nxt;
      blank_r     <= blank_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    out_phase_r <= out_phase_nxt;
  end

  assign empty           = !out_valid_r;
  assign out_frame_word  = out_word_r;
  assign out_blink_phase = out_phase_r;

endmodule
`default_nettype wire

[hw/rtl/sslfb_checker.sv]
`default_nettype none
module sslfb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] out_frame_word,
  input wire logic        out_blink_phase
);

  logic exp_phase_r;

  // Track the phase the next delivered result must carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_phase_r <= 1'b0;
    end else if (pop && !empty) begin
      exp_phase_r <= !exp_phase_r;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("result or input queue not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_frame_word) && $stable(out_blink_phase)))
    else $error("stalled result changed");

  a_phase_alternates: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) |-> (out_blink_phase == exp_phase_r))
    else $error("blink phase out of sequence");

endmodule

bind seven_segment_lcd_frame_builder sslfb_checker u_checker (.*);
`default_nettype wire
